[src/swrbm_pkg.sv]
// ----------------------------------------------------------------------------
// swrbm_pkg
// Shared types and constants for the stereo width / rotate / bass mono block.
// ----------------------------------------------------------------------------
package swrbm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 16;
  localparam int QS          = COEF_BITS - 1;
  localparam int SUM_W       = SAMPLE_BITS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_BITS + 1;

  // 1/sqrt2 in Q1.(C-1), rounded to nearest
  localparam logic [COEF_BITS-1:0] INV_SQRT2 =
    COEF_BITS'((64'd1518500250 + (64'd1 << (31 - COEF_BITS))) >> (32 - COEF_BITS));

  localparam logic [COEF_BITS-1:0] UNITY_Q1   = COEF_BITS'(1) << QS;
  localparam logic [COEF_BITS-1:0] UNITY_Q2   = COEF_BITS'(1) << (COEF_BITS - 2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_GAIN   = 0,
    REG_ROTATE_COS   = 1,
    REG_ROTATE_SIN   = 2,
    REG_LEFT_GAIN    = 3,
    REG_RIGHT_GAIN   = 4,
    REG_LOWPASS_COEF = 5,
    REG_BASS_MONO    = 6
  } cfg_reg_t;

  typedef struct packed {
    logic        [COEF_BITS-1:0] width_gain;
    logic        [COEF_BITS-1:0] rotate_cos;
    logic signed [COEF_BITS:0]   rotate_sin;
    logic        [COEF_BITS-1:0] left_gain;
    logic        [COEF_BITS-1:0] right_gain;
    logic        [COEF_BITS-1:0] lowpass_coef;
    logic                        bass_mono_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_item_t;

  // front end output: L+R and L-R
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] dif;
  } q_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SUMK,
    ST_DIFK,
    ST_MIDC,
    ST_SIDEW,
    ST_MIDS,
    ST_SIDE2S,
    ST_SIDE2C,
    ST_WAIT,
    ST_UK,
    ST_VK,
    ST_LG,
    ST_RG,
    ST_DL,
    ST_LHI,
    ST_RHI,
    ST_LLO,
    ST_RLO,
    ST_LACC,
    ST_RACC,
    ST_LDIF,
    ST_RDIF,
    ST_FIN
  } step_t;

endpackage

[src/swrbm_front.sv]
// ----------------------------------------------------------------------------
// swrbm_front
// Input stage: takes a stereo pair and forms L+R and L-R for the queue.
// ----------------------------------------------------------------------------
module swrbm_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  swrbm_pkg::in_item_t  in_data,
  output logic                 full,
  output logic                 q_push_o,
  output swrbm_pkg::q_item_t   q_item_o,
  input  logic                 q_full_i
);
  import swrbm_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  q_item_t item_r;
  logic    accept;

  assign q_push_o = valid_r && !q_full_i;
  assign full     = valid_r && q_full_i;
  assign accept   = push && !full;
  assign q_item_o = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push_o) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.sum <= SUM_W'(in_data.left_in) + SUM_W'(in_data.right_in);
      item_r.dif <= SUM_W'(in_data.left_in) - SUM_W'(in_data.right_in);
    end
  end

endmodule

[src/swrbm_queue.sv]
// ----------------------------------------------------------------------------
// swrbm_queue
// Small FIFO between the front end and the sequenced datapath.
// ----------------------------------------------------------------------------
module swrbm_queue #(
  parameter int unsigned DEPTH = swrbm_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  swrbm_pkg::q_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output swrbm_pkg::q_item_t item_o
);
  import swrbm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full_o  = (count_r == CNT_W'(DEPTH));
  assign valid_o = (count_r != '0);
  assign item_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (count_r != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (count_r != '0))
    else $error("queue read while empty");

endmodule

[src/swrbm_back.sv]
// ----------------------------------------------------------------------------
// swrbm_back
// Sequenced datapath: one shared multiplier stepped through mid/side, width,
// rotation, balance and the per-channel bass lowpass.
// ----------------------------------------------------------------------------
module swrbm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swrbm_pkg::cfg_t      cfg_i,
  input  logic                 q_valid_i,
  input  swrbm_pkg::q_item_t   q_item_i,
  output logic                 q_pop_o,
  output logic                 res_valid_o,
  output swrbm_pkg::out_item_t res_item_o,
  input  logic                 res_ready_i
);
  import swrbm_pkg::*;

  localparam int SW      = SAMPLE_BITS;
  localparam int CW      = COEF_BITS;
  localparam int LP_FRAC = 16;
  localparam int MID_W   = SW + 1;
  localparam int SIDE2_W = SW + 3;
  localparam int M2_W    = SW + 4;
  localparam int U_W     = SW + 5;
  localparam int A_W     = SW + 5;
  localparam int B_W     = CW + 1;
  localparam int P_W     = A_W + B_W;
  localparam int ACC_W   = SW + LP_FRAC;
  localparam int D_W     = ACC_W + 1;
  localparam int LP_W    = D_W + B_W;
  localparam int LOW_W   = SW + 1;
  localparam int DIF_W   = SW + 2;
  localparam int FIN_W   = SW + 3;

  localparam logic signed [P_W-1:0] SAT_HI =
    {{(P_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [P_W-1:0] SAT_LO =
    {{(P_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
  localparam logic signed [LP_W-1:0]  LP_HALF  = LP_W'(1) << (QS - 1);
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (LP_FRAC - 1);

  function automatic logic signed [P_W-1:0] rnd(input logic signed [P_W-1:0] x,
                                               input int sh);
    logic signed [P_W-1:0] half;
    half = '0;
    half[sh-1] = 1'b1;
    rnd = (x + half) >>> sh;
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [P_W-1:0] x);
    logic signed [P_W-1:0] y;
    y = x;
    if (x > SAT_HI) begin
      y = SAT_HI;
    end else if (x < SAT_LO) begin
      y = SAT_LO;
    end
    sat = SW'(y);
  endfunction

  step_t step_r, step_nxt;
  step_t ret_r;

  logic signed [SUM_W-1:0]   sum_r, dif_r;
  logic signed [MID_W-1:0]   mid_r, side_r;
  logic signed [SIDE2_W-1:0] side2_r;
  logic signed [P_W-1:0]     acc_a_r, acc_b_r;
  logic signed [M2_W-1:0]    m2_r, s2_r;
  logic signed [U_W-1:0]     lb_r, rb_r;
  logic signed [SW-1:0]      lsat_r, rsat_r;
  logic signed [D_W-1:0]     dl_r, dr_r;
  logic signed [LP_W-1:0]    lpl_r, lpr_r;
  logic signed [ACC_W-1:0]   lacc_r, racc_r;
  logic signed [LOW_W-1:0]   lowl_r, lowr_r, avg_r;
  logic signed [DIF_W-1:0]   ldiff_r, rdiff_r;
  logic signed [P_W-1:0]     prod_r;

  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic [CW-1:0]           a0;
  logic signed [FIN_W-1:0] lf, rf;

  // lowpass weight above unity is held at unity
  assign a0 = (cfg_i.lowpass_coef > UNITY_Q1) ? UNITY_Q1 : cfg_i.lowpass_coef;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    step_nxt    = step_r;
    q_pop_o     = 1'b0;
    res_valid_o = 1'b0;
    unique case (step_r)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          step_nxt = ST_SUMK;
        end
      end
      ST_SUMK:   step_nxt = ST_DIFK;
      ST_DIFK:   step_nxt = ST_MIDC;
      ST_MIDC:   step_nxt = ST_SIDEW;
      ST_SIDEW:  step_nxt = ST_MIDS;
      ST_MIDS:   step_nxt = ST_SIDE2S;
      ST_SIDE2S: step_nxt = ST_SIDE2C;
      ST_SIDE2C: step_nxt = ST_WAIT;
      ST_WAIT:   step_nxt = ST_UK;
      ST_UK:     step_nxt = ST_VK;
      ST_VK:     step_nxt = ST_LG;
      ST_LG:     step_nxt = ST_RG;
      ST_RG:     step_nxt = ST_DL;
      ST_DL:     step_nxt = cfg_i.bass_mono_enable ? ST_LHI : ST_FIN;
      ST_LHI:    step_nxt = ST_RHI;
      ST_RHI:    step_nxt = ST_LLO;
      ST_LLO:    step_nxt = ST_RLO;
      ST_RLO:    step_nxt = ST_LACC;
      ST_LACC:   step_nxt = ST_RACC;
      ST_RACC:   step_nxt = ST_LDIF;
      ST_LDIF:   step_nxt = ST_RDIF;
      ST_RDIF:   step_nxt = ST_FIN;
      ST_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (q_valid_i) begin
            q_pop_o  = 1'b1;
            step_nxt = ST_SUMK;
          end else begin
            step_nxt = ST_IDLE;
          end
        end
      end
      default:   step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
      ret_r  <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
      ret_r  <= step_r;
    end
  end

  // --------------------------------------------------------------------------
  // Multiplier operands (pre-adder for the back conversion)
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_r)
      ST_SUMK: begin
        mul_a = A_W'(sum_r);
        mul_b = {1'b0, INV_SQRT2};
      end
      ST_DIFK: begin
        mul_a = A_W'(dif_r);
        mul_b = {1'b0, INV_SQRT2};
      end
      ST_MIDC: begin
        mul_a = A_W'(mid_r);
        mul_b = {1'b0, cfg_i.rotate_cos};
      end
      ST_SIDEW: begin
        mul_a = A_W'(side_r);
        mul_b = {1'b0, cfg_i.width_gain};
      end
      ST_MIDS: begin
        mul_a = A_W'(mid_r);
        mul_b = cfg_i.rotate_sin;
      end
      ST_SIDE2S: begin
        mul_a = A_W'(side2_r);
        mul_b = cfg_i.rotate_sin;
      end
      ST_SIDE2C: begin
        mul_a = A_W'(side2_r);
        mul_b = {1'b0, cfg_i.rotate_cos};
      end
      ST_UK: begin
        mul_a = A_W'(m2_r) + A_W'(s2_r);
        mul_b = {1'b0, INV_SQRT2};
      end
      ST_VK: begin
        mul_a = A_W'(m2_r) - A_W'(s2_r);
        mul_b = {1'b0, INV_SQRT2};
      end
      ST_LG: begin
        mul_a = A_W'(lb_r);
        mul_b = {1'b0, cfg_i.left_gain};
      end
      ST_RG: begin
        mul_a = A_W'(rb_r);
        mul_b = {1'b0, cfg_i.right_gain};
      end
      ST_LHI: begin
        mul_a = A_W'($signed(dl_r[D_W-1:LP_FRAC]));
        mul_b = {1'b0, a0};
      end
      ST_RHI: begin
        mul_a = A_W'($signed(dr_r[D_W-1:LP_FRAC]));
        mul_b = {1'b0, a0};
      end
      ST_LLO: begin
        mul_a = A_W'({1'b0, dl_r[LP_FRAC-1:0]});
        mul_b = {1'b0, a0};
      end
      ST_RLO: begin
        mul_a = A_W'({1'b0, dr_r[LP_FRAC-1:0]});
        mul_b = {1'b0, a0};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath: issue-side ALU steps and retire of the previous product
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= P_W'(mul_a) * P_W'(mul_b);

    if (q_pop_o) begin
      sum_r <= q_item_i.sum;
      dif_r <= q_item_i.dif;
    end

    unique case (step_r)
      ST_DL: begin
        dl_r <= D_W'(ACC_W'(lsat_r) <<< LP_FRAC) - D_W'(lacc_r);
      end
      ST_LHI: begin
        dr_r <= D_W'(ACC_W'(rsat_r) <<< LP_FRAC) - D_W'(racc_r);
      end
      ST_RACC: begin
        lowl_r <= LOW_W'((lacc_r + ACC_HALF) >>> LP_FRAC);
      end
      ST_LDIF: begin
        lowr_r  <= LOW_W'((racc_r + ACC_HALF) >>> LP_FRAC);
        ldiff_r <= DIF_W'(lsat_r) - DIF_W'(lowl_r);
      end
      ST_RDIF: begin
        rdiff_r <= DIF_W'(rsat_r) - DIF_W'(lowr_r);
        avg_r   <= LOW_W'((DIF_W'(lowl_r) + DIF_W'(lowr_r) + DIF_W'(1)) >>> 1);
      end
      default: begin
      end
    endcase

    unique case (ret_r)
      ST_SUMK:   mid_r   <= MID_W'(rnd(prod_r, QS));
      ST_DIFK:   side_r  <= MID_W'(rnd(prod_r, QS));
      ST_MIDC:   acc_a_r <= prod_r;
      ST_SIDEW:  side2_r <= SIDE2_W'(rnd(prod_r, CW - 2));
      ST_MIDS:   acc_b_r <= prod_r;
      ST_SIDE2S: m2_r    <= M2_W'(rnd(acc_a_r - prod_r, QS));
      ST_SIDE2C: s2_r    <= M2_W'(rnd(acc_b_r + prod_r, QS));
      ST_UK:     lb_r    <= U_W'(rnd(prod_r, QS));
      ST_VK:     rb_r    <= U_W'(rnd(prod_r, QS));
      ST_LG:     lsat_r  <= sat(rnd(prod_r, QS));
      ST_RG:     rsat_r  <= sat(rnd(prod_r, QS));
      // high partial product carries the rounding half
      ST_LHI:    lpl_r   <= (LP_W'(prod_r) <<< LP_FRAC) + LP_HALF;
      ST_RHI:    lpr_r   <= (LP_W'(prod_r) <<< LP_FRAC) + LP_HALF;
      ST_LLO:    lpl_r   <= lpl_r + LP_W'(prod_r);
      ST_RLO:    lpr_r   <= lpr_r + LP_W'(prod_r);
      default: begin
      end
    endcase
  end

  // filter states: the only datapath state that survives between items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lacc_r <= '0;
      racc_r <= '0;
    end else begin
      if (step_r == ST_LACC) begin
        lacc_r <= lacc_r + ACC_W'(lpl_r >>> QS);
      end
      if (step_r == ST_RACC) begin
        racc_r <= racc_r + ACC_W'(lpr_r >>> QS);
      end
    end
  end

  assign lf = cfg_i.bass_mono_enable ? (FIN_W'(ldiff_r) + FIN_W'(avg_r)) : FIN_W'(lsat_r);
  assign rf = cfg_i.bass_mono_enable ? (FIN_W'(rdiff_r) + FIN_W'(avg_r)) : FIN_W'(rsat_r);

  assign res_item_o.left_out  = sat(P_W'(lf));
  assign res_item_o.right_out = sat(P_W'(rf));

  a_start_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_SUMK) |-> $past(q_pop_o))
    else $error("item started without a queue read");

  a_filter_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_IDLE) |=> ($stable(lacc_r) && $stable(racc_r)))
    else $error("filter state moved while idle");

endmodule

[src/stereo_width_rotate_bass_mono.sv]
// A pair accepted on push passes the front register, the queue, the sequenced datapath
//   and the output register; with bass mono on, the datapath adds the lowpass steps.
// The datapath works on one pair at a time, as every product of the item goes through
//   the single shared multiplier in turn; a finished pair waits until the output register takes it.
// Reset (rst_n low, synchronous): queues empty, registers at their defaults, filter
//   states cleared.
// ----------------------------------------------------------------------------
// stereo_width_rotate_bass_mono
// Mid/side stereo width, rotation, balance and bass mono on Q1.23 sample pairs.
// ----------------------------------------------------------------------------
module stereo_width_rotate_bass_mono #(
  parameter int unsigned Q_DEPTH = swrbm_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  swrbm_pkg::in_item_t                 in_data,
  output logic                                empty,
  input  logic                                pop,
  output swrbm_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [swrbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swrbm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import swrbm_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      fq_push;
  q_item_t   fq_item;
  logic      fq_full;
  logic      q_valid;
  q_item_t   q_item;
  logic      q_pop;
  logic      res_valid;
  out_item_t res_item;
  logic      res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_gain       <= UNITY_Q2;
      cfg_r.rotate_cos       <= UNITY_Q1;
      cfg_r.rotate_sin       <= '0;
      cfg_r.left_gain        <= UNITY_Q1;
      cfg_r.right_gain       <= UNITY_Q1;
      cfg_r.lowpass_coef     <= '0;
      cfg_r.bass_mono_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH_GAIN:   cfg_r.width_gain       <= cfg_data[COEF_BITS-1:0];
        REG_ROTATE_COS:   cfg_r.rotate_cos       <= cfg_data[COEF_BITS-1:0];
        REG_ROTATE_SIN:   cfg_r.rotate_sin       <= cfg_data;
        REG_LEFT_GAIN:    cfg_r.left_gain        <= cfg_data[COEF_BITS-1:0];
        REG_RIGHT_GAIN:   cfg_r.right_gain       <= cfg_data[COEF_BITS-1:0];
        REG_LOWPASS_COEF: cfg_r.lowpass_coef     <= cfg_data[COEF_BITS-1:0];
        REG_BASS_MONO:    cfg_r.bass_mono_enable <= cfg_data[0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  swrbm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .q_push_o (fq_push),
    .q_item_o (fq_item),
    .q_full_i (fq_full)
  );

  swrbm_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (fq_push),
    .item_i  (fq_item),
    .full_o  (fq_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  swrbm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_item_o  (res_item),
    .res_ready_i (res_ready)
  );

  // output register: the datapath moves on while a result waits here
  assign res_ready = !out_valid_r || pop;
  assign empty     = !out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_item;
    end
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stereo_width_rotate_bass_mono. Sample pairs go in
// through the push/full queue in random bursts. A built-in fixed point
// predictor of the mid/side, rotation, balance and bass mono path gives the
// expected pair for each accepted item. Results are popped under a changing
// stall pattern and compared field by field. Settings are changed between
// phases, only after every pending result has drained.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swrbm_pkg::*;

  localparam int LOW_FRAC = 16;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_BITS - 1));
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int END_SETTLE = 40;

  typedef enum {POP_OPEN, POP_TOGGLE, POP_RANDOM, POP_HOLD} pop_mode_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_item_t in_data;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the settings and filter states
  cfg_t live_cfg;
  longint left_low;
  longint right_low;
  out_item_t pending_pairs[$];
  int fail_count = 0;

  // sender burst state
  int burst_left = 0;
  bit gaps_on = 1'b1;

  pop_mode_t pop_mode = POP_OPEN;
  int pop_run = 0;

  stereo_width_rotate_bass_mono uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint rnd_shr(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip_sample(longint x);
    if (x > SAMPLE_MAX) return SAMPLE_MAX;
    if (x < SAMPLE_MIN) return SAMPLE_MIN;
    return x;
  endfunction

  // full datapath for one pair; advances the lowpass states when bass mono is on
  function automatic out_item_t mix_pair(in_item_t it);
    longint l, r, k, c, s, mid, side, m2, s2, a0, lo_l, lo_r, avg;
    out_item_t o;
    l = longint'($signed(it.left_in));
    r = longint'($signed(it.right_in));
    k = longint'(INV_SQRT2);
    c = longint'(live_cfg.rotate_cos);
    s = longint'($signed(live_cfg.rotate_sin));

    mid = rnd_shr((l + r) * k, QS);
    side = rnd_shr((l - r) * k, QS);
    side = rnd_shr(side * longint'(live_cfg.width_gain), COEF_BITS - 2);
    m2 = rnd_shr(mid * c - side * s, QS);
    s2 = rnd_shr(mid * s + side * c, QS);
    l = rnd_shr((m2 + s2) * k, QS);
    r = rnd_shr((m2 - s2) * k, QS);
    // clamp after balance so the filter input stays in sample range
    l = clip_sample(rnd_shr(l * longint'(live_cfg.left_gain), QS));
    r = clip_sample(rnd_shr(r * longint'(live_cfg.right_gain), QS));

    if (live_cfg.bass_mono_enable) begin
      a0 = longint'(live_cfg.lowpass_coef);
      if (a0 > longint'(UNITY_Q1)) a0 = longint'(UNITY_Q1);
      left_low = left_low + rnd_shr(a0 * ((l <<< LOW_FRAC) - left_low), QS);
      right_low = right_low + rnd_shr(a0 * ((r <<< LOW_FRAC) - right_low), QS);
      lo_l = rnd_shr(left_low, LOW_FRAC);
      lo_r = rnd_shr(right_low, LOW_FRAC);
      avg = rnd_shr(lo_l + lo_r, 1);
      l = l - lo_l + avg;
      r = r - lo_r + avg;
    end

    o.left_out = SAMPLE_BITS'(clip_sample(l));
    o.right_out = SAMPLE_BITS'(clip_sample(r));
    return o;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] v;
    v = SAMPLE_BITS'($urandom);
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : SAMPLE_BITS'(SAMPLE_MIN);
      1: v = v >>> $urandom_range(8, 22);
      2: v = SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
      default: ;
    endcase
    return v;
  endfunction

  // watch both channels and the register port at each rising edge
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      live_cfg.width_gain = UNITY_Q2;
      live_cfg.rotate_cos = UNITY_Q1;
      live_cfg.rotate_sin = '0;
      live_cfg.left_gain = UNITY_Q1;
      live_cfg.right_gain = UNITY_Q1;
      live_cfg.lowpass_coef = '0;
      live_cfg.bass_mono_enable = 1'b0;
      left_low = 0;
      right_low = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_WIDTH_GAIN:   live_cfg.width_gain = cfg_data[COEF_BITS-1:0];
          REG_ROTATE_COS:   live_cfg.rotate_cos = cfg_data[COEF_BITS-1:0];
          REG_ROTATE_SIN:   live_cfg.rotate_sin = cfg_data;
          REG_LEFT_GAIN:    live_cfg.left_gain = cfg_data[COEF_BITS-1:0];
          REG_RIGHT_GAIN:   live_cfg.right_gain = cfg_data[COEF_BITS-1:0];
          REG_LOWPASS_COEF: live_cfg.lowpass_coef = cfg_data[COEF_BITS-1:0];
          REG_BASS_MONO:    live_cfg.bass_mono_enable = cfg_data[0];
          default: ;
        endcase
      end
      if (push && !full) pending_pairs.push_back(mix_pair(in_data));
      if (pop && !empty) begin
        if (pending_pairs.size() == 0) begin
          $error("result item with no item pending: left_out %0d right_out %0d",
                 out_data.left_out, out_data.right_out);
          fail_count++;
        end else begin
          want = pending_pairs.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $error("left_out expected %0d got %0d", want.left_out, out_data.left_out);
            fail_count++;
          end
          if (out_data.right_out !== want.right_out) begin
            $error("right_out expected %0d got %0d", want.right_out, out_data.right_out);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stall pattern: open, toggling, random and held-off stretches
  always @(negedge clk) begin
    if (pop_run == 0) begin
      pop_mode = pop_mode_t'($urandom_range(0, 3));
      pop_run = $urandom_range(1, 40);
    end else begin
      pop_run--;
    end
    case (pop_mode)
      POP_OPEN:   pop <= 1'b1;
      POP_TOGGLE: pop <= ~pop;
      POP_RANDOM: pop <= 1'(($urandom_range(0, 1)));
      default:    pop <= 1'b0;
    endcase
  end

  task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(1, 20) : 0;
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    in_data <= '{left_in: l, right_in: r};
    do @(posedge clk); while (full);
  endtask

  // hold the input side until every pending result has been popped
  task automatic wait_results_drained();
    @(negedge clk);
    push <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_unity_extremes();
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MAX));
    send_pair('0, '0);
    send_pair(-24'sd1, -24'sd1);
    send_pair(24'sd1, -24'sd1);
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), '0);
  endtask

  task automatic test_register_extremes();
    wait_results_drained();
    // out-of-range settings are used as written; output saturation bounds them
    write_reg(REG_WIDTH_GAIN, 17'h0FFFF);
    write_reg(REG_ROTATE_COS, 17'h0FFFF);
    write_reg(REG_ROTATE_SIN, CFG_DATA_W'(-32768));
    write_reg(REG_LEFT_GAIN, 17'h0FFFF);
    write_reg(REG_RIGHT_GAIN, 17'h0FFFF);
    // unknown index must be ignored
    write_reg(REG_UNUSED, 17'h00000);
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(24'sd1000, -24'sd3000);
    wait_results_drained();
    write_reg(REG_WIDTH_GAIN, '0);
    write_reg(REG_ROTATE_COS, '0);
    write_reg(REG_ROTATE_SIN, CFG_DATA_W'(32768));
    write_reg(REG_LEFT_GAIN, '0);
    write_reg(REG_RIGHT_GAIN, CFG_DATA_W'(UNITY_Q1));
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), 24'sd12345);
  endtask

  task automatic test_bass_mono_merge();
    wait_results_drained();
    write_reg(REG_WIDTH_GAIN, CFG_DATA_W'(UNITY_Q2));
    write_reg(REG_ROTATE_COS, CFG_DATA_W'(UNITY_Q1));
    write_reg(REG_ROTATE_SIN, '0);
    write_reg(REG_LEFT_GAIN, CFG_DATA_W'(UNITY_Q1));
    // coefficient above unity saturates to unity
    write_reg(REG_LOWPASS_COEF, 17'h0FFFF);
    write_reg(REG_BASS_MONO, 17'h00001);
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MIN));
    send_pair(24'sd400000, -24'sd77);
    wait_results_drained();
    // zero coefficient: states hold and still drive the swap
    write_reg(REG_LOWPASS_COEF, '0);
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), SAMPLE_BITS'(SAMPLE_MAX));
    send_pair('0, '0);
    wait_results_drained();
    write_reg(REG_BASS_MONO, '0);
    send_pair(24'sd5000, -24'sd5000);
    wait_results_drained();
    write_reg(REG_LOWPASS_COEF, 17'd100);
    write_reg(REG_BASS_MONO, 17'h00001);
    send_pair(SAMPLE_BITS'(SAMPLE_MAX), SAMPLE_BITS'(SAMPLE_MAX));
    send_pair(SAMPLE_BITS'(SAMPLE_MIN), 24'sd1);
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    cfg_reg_t which;
    logic [CFG_DATA_W-1:0] v;
    logic signed [SAMPLE_BITS-1:0] a, b;
    for (int p = 0; p < phases; p++) begin
      wait_results_drained();
      for (int i = 0; i <= REG_BASS_MONO; i++) begin
        which = cfg_reg_t'(i);
        v = CFG_DATA_W'($urandom);
        case (which)
          REG_WIDTH_GAIN:
            case ($urandom_range(0, 5))
              0: v[COEF_BITS-1:0] = '0;
              1: v[COEF_BITS-1:0] = UNITY_Q2;
              2: v[COEF_BITS-1:0] = 16'd49152;
              3: v[COEF_BITS-1:0] = '1;
              default: v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(0, 49152));
            endcase
          REG_ROTATE_SIN:
            case ($urandom_range(0, 5))
              0: v = CFG_DATA_W'(-32768);
              1: v = CFG_DATA_W'(32768);
              2: v = '0;
              3: ;
              default: v = CFG_DATA_W'(int'($urandom_range(0, 65536)) - 32768);
            endcase
          REG_LOWPASS_COEF:
            case ($urandom_range(0, 5))
              0: v[COEF_BITS-1:0] = '0;
              1: v[COEF_BITS-1:0] = UNITY_Q1;
              2: v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(32769, 65535));
              3: v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(1, 2000));
              default: v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(0, 32768));
            endcase
          REG_BASS_MONO:
            v[0] = ($urandom_range(0, 2) != 0);
          default:
            // cos and the balance gains
            case ($urandom_range(0, 5))
              0: v[COEF_BITS-1:0] = '0;
              1: v[COEF_BITS-1:0] = UNITY_Q1;
              2: v[COEF_BITS-1:0] = '1;
              default: v[COEF_BITS-1:0] = COEF_BITS'($urandom_range(0, 32768));
            endcase
        endcase
        write_reg(which, v);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      gaps_on = ($urandom_range(0, 3) != 0);
      burst_left = 0;
      for (int n = 0; n < per_phase; n++) begin
        a = pick_sample();
        b = pick_sample();
        case ($urandom_range(0, 5))
          0: b = a;
          1: b = -a;
          default: ;
        endcase
        send_pair(a, b);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unity_extremes();
    test_register_extremes();
    test_bass_mono_merge();
    test_random_phases(14, 50);

    wait_results_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("stereo_width_rotate_bass_mono verification clean");
    end else begin
      $display("stereo_width_rotate_bass_mono verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("stereo_width_rotate_bass_mono verification failed");
    $finish;
  end

endmodule

[files.f]
src/swrbm_pkg.sv
src/swrbm_front.sv
src/swrbm_queue.sv
src/swrbm_back.sv
src/stereo_width_rotate_bass_mono.sv
test/testbench.sv
